// File: rtl/mssa_pkg.sv
package mssa_pkg;

	// Default sizing
	localparam int TOTAL_SLOTS_DEF = 16;
	localparam int MAX_STACKS_DEF  = 16;
	localparam int ENTRY_BITS_DEF  = 64;

	// Fixed field widths
	localparam int CMD_W    = 2;
	localparam int STACK_W  = 4;
	localparam int VALUE_W  = 64;
	localparam int STATUS_W = 3;
	localparam int CFG_W    = 5;

	// A list emits at most this many entries
	localparam int RESULT_LIMIT = 16;
	localparam int LIMIT_W      = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_LIST = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_PUSHED    = 3'd0,
		ST_POPPED    = 3'd1,
		ST_LISTED    = 3'd2,
		ST_FULL      = 3'd3,
		ST_EMPTY     = 3'd4,
		ST_BAD_STACK = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_LIST
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic    capture;
		logic    top_wr;
		logic    slot_wr;
		logic    slot_rd;
		logic    list_start;
		logic    list_step;
		logic    emit;
		status_t emit_status;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic bad;
		logic full;
		logic empty;
		logic out_free;
		logic list_last;
		logic busy;
	} dp_stat_t;

endpackage

// File: rtl/mssa_req_if.sv
interface mssa_req_if;
	logic                          valid;
	logic                          ready;
	logic [mssa_pkg::CMD_W-1:0]    cmd;
	logic [mssa_pkg::STACK_W-1:0]  stack_number;
	logic [mssa_pkg::VALUE_W-1:0]  entry_value;

	modport source (output valid, output cmd, output stack_number, output entry_value,
		input ready);
	modport sink (input valid, input cmd, input stack_number, input entry_value,
		output ready);
endinterface

// File: rtl/mssa_rsp_if.sv
interface mssa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [mssa_pkg::STATUS_W-1:0] status;
	logic [mssa_pkg::VALUE_W-1:0]  value_out;
	logic [mssa_pkg::STACK_W-1:0]  stack_out;
	logic                          last;

	modport source (output valid, output status, output value_out, output stack_out,
		output last, input ready);
	modport sink (input valid, input status, input value_out, input stack_out,
		input last, output ready);
endinterface

// File: rtl/mssa_datapath.sv
module mssa_datapath #(
	parameter int TOTAL_SLOTS = mssa_pkg::TOTAL_SLOTS_DEF,
	parameter int MAX_STACKS  = mssa_pkg::MAX_STACKS_DEF,
	parameter int ENTRY_BITS  = mssa_pkg::ENTRY_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mssa_pkg::ctl_cmd_t              ctl,
	output mssa_pkg::dp_stat_t              stat,
	input  logic                            cfg_we,
	input  logic [mssa_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic [mssa_pkg::CMD_W-1:0]      req_cmd,
	input  logic [mssa_pkg::STACK_W-1:0]    req_stack,
	input  logic [mssa_pkg::VALUE_W-1:0]    req_value,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [mssa_pkg::STATUS_W-1:0]   rsp_status,
	output logic [mssa_pkg::VALUE_W-1:0]    rsp_value,
	output logic [mssa_pkg::STACK_W-1:0]    rsp_stack,
	output logic                            rsp_last
);

	localparam int AW    = $clog2(TOTAL_SLOTS);
	localparam int SW    = $clog2(TOTAL_SLOTS + 1);
	localparam int CW    = $clog2(MAX_STACKS + 1);
	localparam int SA_W  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
	localparam int CMP_W = (CW > mssa_pkg::CFG_W) ? CW : mssa_pkg::CFG_W;
	localparam int DCW   = $clog2(SW + 1);
	localparam int RW    = (SW > mssa_pkg::LIMIT_W) ? SW : mssa_pkg::LIMIT_W;
	localparam int PW    = mssa_pkg::STACK_W + SW;

	// Captured command
	mssa_pkg::cmd_t                 cmd_q;
	logic [mssa_pkg::STACK_W-1:0]   stk_q;
	logic [ENTRY_BITS-1:0]          entry_q;

	// Top count store with per-stack valid bits
	logic [SW-1:0]          top_mem [MAX_STACKS];
	logic [MAX_STACKS-1:0]  top_vld_q;
	logic [SW-1:0]          top_rd_q;
	logic                   top_hit_q;

	// Slot store
	logic [ENTRY_BITS-1:0]  slot_mem [TOTAL_SLOTS];
	logic [ENTRY_BITS-1:0]  rd_q;

	// Segment layout: quotient and remainder of the layout divider
	logic [CW-1:0]          cnt_eff_q;
	logic [CW-1:0]          cfg_eff;
	logic [SW-1:0]          div_quo_q;
	logic [CW-1:0]          div_rem_q;
	logic [DCW-1:0]         div_cnt_q;
	logic [CW:0]            div_shift;
	logic [CW:0]            div_trial;

	// List walk
	logic [AW-1:0]                  ptr_q;
	logic [mssa_pkg::LIMIT_W-1:0]   remain_q;
	logic [mssa_pkg::LIMIT_W-1:0]   remain_d;

	// Result register
	logic                           out_vld_q;
	logic [mssa_pkg::STATUS_W-1:0]  status_q;
	logic [mssa_pkg::VALUE_W-1:0]   value_q;
	logic [mssa_pkg::STACK_W-1:0]   stack_q;
	logic                           last_q;

	// Address math
	logic [SA_W-1:0]  req_idx;
	logic [SA_W-1:0]  stk_idx;
	logic [PW-1:0]    base_prod;
	logic [SW-1:0]    base;
	logic [SW-1:0]    cap;
	logic [SW-1:0]    top_raw;
	logic [SW-1:0]    top;
	logic [SW-1:0]    top_wr_data;
	logic [AW-1:0]    push_addr;
	logic [AW-1:0]    top_addr;
	logic [AW-1:0]    rd_addr;
	logic             is_last_stack;
	logic             bad;
	logic             out_free;
	logic             rd_en;
	logic             rd_data_sel;

	assign req_idx = SA_W'(req_stack);
	assign stk_idx = SA_W'(stk_q);

	// Capture on a request transfer
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q     <= mssa_pkg::cmd_t'(req_cmd);
			stk_q     <= req_stack;
			entry_q   <= ENTRY_BITS'(req_value);
			top_rd_q  <= top_mem[req_idx];
			top_hit_q <= top_vld_q[req_idx];
		end
		if (ctl.top_wr) begin
			top_mem[stk_idx] <= top_wr_data;
		end
	end

	// Valid bits: cleared by reset and by a layout change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_vld_q <= '0;
		end else if (cfg_we) begin
			top_vld_q <= '0;
		end else if (ctl.top_wr) begin
			top_vld_q[stk_idx] <= 1'b1;
		end
	end

	// Clamp written stack count to 1..MAX_STACKS
	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_eff = CW'(1);
		end else if (CMP_W'(cfg_wdata) > CMP_W'(MAX_STACKS)) begin
			cfg_eff = CW'(MAX_STACKS);
		end else begin
			cfg_eff = CW'(cfg_wdata);
		end
	end

	// Restoring divider step: TOTAL_SLOTS / cnt_eff_q, one quotient bit per cycle
	assign div_shift = {div_rem_q, div_quo_q[SW-1]};
	assign div_trial = div_shift - {1'b0, cnt_eff_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_eff_q <= CW'(1);
			div_quo_q <= SW'(TOTAL_SLOTS);
			div_rem_q <= '0;
			div_cnt_q <= '0;
		end else if (cfg_we) begin
			cnt_eff_q <= cfg_eff;
			div_quo_q <= SW'(TOTAL_SLOTS);
			div_rem_q <= '0;
			div_cnt_q <= DCW'(SW);
		end else if (div_cnt_q != '0) begin
			if (!div_trial[CW]) begin
				div_rem_q <= div_trial[CW-1:0];
				div_quo_q <= {div_quo_q[SW-2:0], 1'b1};
			end else begin
				div_rem_q <= div_shift[CW-1:0];
				div_quo_q <= {div_quo_q[SW-2:0], 1'b0};
			end
			div_cnt_q <= div_cnt_q - DCW'(1);
		end
	end

	// Segment of the captured stack
	always_comb begin
		bad           = CMP_W'(stk_q) >= CMP_W'(cnt_eff_q);
		is_last_stack = (CMP_W'(stk_q) + CMP_W'(1)) == CMP_W'(cnt_eff_q);
		base_prod     = PW'(stk_q) * PW'(div_quo_q);
		base          = SW'(base_prod);
		cap           = div_quo_q + (is_last_stack ? SW'(div_rem_q) : '0);
		top_raw       = top_hit_q ? top_rd_q : '0;
		top           = (top_raw > cap) ? cap : top_raw;
		push_addr     = AW'(base + top);
		top_addr      = AW'(base + top - SW'(1));
		top_wr_data   = (cmd_q == mssa_pkg::CMD_PUSH) ? (top + SW'(1)) : (top - SW'(1));
		remain_d      = (RW'(top) > RW'(mssa_pkg::RESULT_LIMIT))
			? mssa_pkg::LIMIT_W'(mssa_pkg::RESULT_LIMIT) : mssa_pkg::LIMIT_W'(top);
	end

	// Slot store: one write, one registered read
	assign rd_en   = ctl.slot_rd | ctl.list_step;
	assign rd_addr = ctl.slot_rd ? top_addr : (ptr_q - AW'(1));

	always_ff @(posedge clk) begin
		if (ctl.slot_wr) begin
			slot_mem[push_addr] <= entry_q;
		end
		if (rd_en) begin
			rd_q <= slot_mem[rd_addr];
		end
	end

	// List walk pointer and remaining count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			remain_q <= '0;
		end else if (ctl.list_start) begin
			ptr_q    <= top_addr;
			remain_q <= remain_d;
		end else if (ctl.list_step) begin
			ptr_q    <= ptr_q - AW'(1);
			remain_q <= remain_q - mssa_pkg::LIMIT_W'(1);
		end
	end

	// Result register
	assign out_free    = !out_vld_q || rsp_ready;
	assign rd_data_sel = (ctl.emit_status == mssa_pkg::ST_POPPED) ||
		(ctl.emit_status == mssa_pkg::ST_LISTED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctl.emit) begin
			out_vld_q <= 1'b1;
		end else if (rsp_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			status_q <= ctl.emit_status;
			value_q  <= rd_data_sel ? mssa_pkg::VALUE_W'(rd_q) : '0;
			stack_q  <= stk_q;
			last_q   <= (ctl.emit_status == mssa_pkg::ST_LISTED)
				? (remain_q == mssa_pkg::LIMIT_W'(1)) : 1'b1;
		end
	end

	assign rsp_valid  = out_vld_q;
	assign rsp_status = status_q;
	assign rsp_value  = value_q;
	assign rsp_stack  = stack_q;
	assign rsp_last   = last_q;

	// Status to the controller
	always_comb begin
		stat.cmd       = cmd_q;
		stat.bad       = bad;
		stat.full      = top >= cap;
		stat.empty     = top == '0;
		stat.out_free  = out_free;
		stat.list_last = remain_q == mssa_pkg::LIMIT_W'(1);
		stat.busy      = div_cnt_q != '0;
	end

endmodule

// File: rtl/mssa_ctrl.sv
module mssa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  mssa_pkg::dp_stat_t  stat,
	output mssa_pkg::ctl_cmd_t  ctl
);

	mssa_pkg::state_t state_q;
	mssa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mssa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mssa_pkg::S_IDLE: begin
				if (req_valid && !stat.busy) begin
					state_d = mssa_pkg::S_EXEC;
				end
			end
			mssa_pkg::S_EXEC: begin
				if (stat.cmd == mssa_pkg::CMD_NOP) begin
					state_d = mssa_pkg::S_IDLE;
				end else if (stat.out_free) begin
					if (stat.bad || stat.empty || stat.cmd == mssa_pkg::CMD_PUSH) begin
						state_d = mssa_pkg::S_IDLE;
					end else if (stat.cmd == mssa_pkg::CMD_POP) begin
						state_d = mssa_pkg::S_POP;
					end else begin
						state_d = mssa_pkg::S_LIST;
					end
				end
			end
			mssa_pkg::S_POP: begin
				if (stat.out_free) begin
					state_d = mssa_pkg::S_IDLE;
				end
			end
			mssa_pkg::S_LIST: begin
				if (stat.out_free && stat.list_last) begin
					state_d = mssa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mssa_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		req_ready = 1'b0;
		ctl       = '0;
		ctl.emit_status = mssa_pkg::ST_PUSHED;
		case (state_q)
			mssa_pkg::S_IDLE: begin
				req_ready   = !stat.busy;
				ctl.capture = req_valid && !stat.busy;
			end
			mssa_pkg::S_EXEC: begin
				if (stat.cmd != mssa_pkg::CMD_NOP && stat.out_free) begin
					if (stat.bad) begin
						ctl.emit        = 1'b1;
						ctl.emit_status = mssa_pkg::ST_BAD_STACK;
					end else begin
						case (stat.cmd)
							mssa_pkg::CMD_PUSH: begin
								ctl.emit = 1'b1;
								if (stat.full) begin
									ctl.emit_status = mssa_pkg::ST_FULL;
								end else begin
									ctl.emit_status = mssa_pkg::ST_PUSHED;
									ctl.slot_wr     = 1'b1;
									ctl.top_wr      = 1'b1;
								end
							end
							mssa_pkg::CMD_POP: begin
								if (stat.empty) begin
									ctl.emit        = 1'b1;
									ctl.emit_status = mssa_pkg::ST_EMPTY;
								end else begin
									ctl.top_wr  = 1'b1;
									ctl.slot_rd = 1'b1;
								end
							end
							mssa_pkg::CMD_LIST: begin
								if (stat.empty) begin
									ctl.emit        = 1'b1;
									ctl.emit_status = mssa_pkg::ST_EMPTY;
								end else begin
									ctl.slot_rd    = 1'b1;
									ctl.list_start = 1'b1;
								end
							end
							default: begin
								ctl.emit = 1'b0;
							end
						endcase
					end
				end
			end
			mssa_pkg::S_POP: begin
				if (stat.out_free) begin
					ctl.emit        = 1'b1;
					ctl.emit_status = mssa_pkg::ST_POPPED;
				end
			end
			mssa_pkg::S_LIST: begin
				if (stat.out_free) begin
					ctl.emit        = 1'b1;
					ctl.emit_status = mssa_pkg::ST_LISTED;
					ctl.list_step   = 1'b1;
				end
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/multi_stack_shared_array_unit.sv
// Several LIFO stacks in one shared store of TOTAL_SLOTS words. The store is split into
// stack_count equal segments; the last stack also owns the remainder slots. Each request
// (push, pop or list) names a stack and gets one response, except a list, which returns
// up to 16 entries top to bottom with last set on the final one; command code 3 returns
// nothing. A request is taken one at a time. A pop and each list entry are read through
// the single read port of the slot store, and a stalled response holds back the next one.
// A response waits in an output register, so the next request can be taken while it is
// still held. Writing stack_count empties all stacks and restarts the segment-size
// divider, which holds off requests until it has finished.
module multi_stack_shared_array_unit #(
	parameter int TOTAL_SLOTS = mssa_pkg::TOTAL_SLOTS_DEF,
	parameter int MAX_STACKS  = mssa_pkg::MAX_STACKS_DEF,
	parameter int ENTRY_BITS  = mssa_pkg::ENTRY_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	mssa_req_if.sink                    req,
	mssa_rsp_if.source                  rsp,
	input  logic                        cfg_we,
	input  logic [mssa_pkg::CFG_W-1:0]  cfg_wdata
);

	mssa_pkg::ctl_cmd_t ctl;
	mssa_pkg::dp_stat_t stat;

	// Sequencer
	mssa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// Stores, layout divider and result register
	mssa_datapath #(
		.TOTAL_SLOTS (TOTAL_SLOTS),
		.MAX_STACKS  (MAX_STACKS),
		.ENTRY_BITS  (ENTRY_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_cmd    (req.cmd),
		.req_stack  (req.stack_number),
		.req_value  (req.entry_value),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_status (rsp.status),
		.rsp_value  (rsp.value_out),
		.rsp_stack  (rsp.stack_out),
		.rsp_last   (rsp.last)
	);

endmodule
